FILE: hw/rtl/glob_basename_matcher_assert.svh
// Assertion macros for the glob basename matcher.
// Used by glob_basename_matcher.sv; expects signals named clock and reset in scope.
`ifndef GLOB_BASENAME_MATCHER_ASSERT_SVH
`define GLOB_BASENAME_MATCHER_ASSERT_SVH

// same-cycle implication
`define GBM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/gbm_pkg.sv
// Shared types, character codes and case folding for the glob basename matcher.
// No dependencies.
`timescale 1ns / 1ps

package gbm_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_PATH = 2'd1,
      REQ_END  = 2'd2
   } req_kind_type;

   typedef enum logic {
      REG_CASE_INSENSITIVE = 1'b0,
      REG_PATTERN_LENGTH   = 1'b1
   } csr_index_type;

   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_QMARK     = 8'h3F;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH    = 8'h5C;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET    = 8'h20;
   localparam logic [7:0] NAME_COUNT_MAX = 8'hFF;

   // ASCII upper to lower when folding is on
   function automatic logic [7:0] fold_char(input logic fold_en, input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (fold_en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/gbm_star_close.sv
// Star closure: spreads active positions forward across runs of '*' in one carry chain.
// Depends on nothing; instanced by glob_basename_matcher.
`timescale 1ns / 1ps

module gbm_star_close #(
   parameter int DEPTH = 256
) (
   input  logic [DEPTH-1:0] star_mask,   // star at position i, already limited to length
   input  logic [DEPTH:0]   seed_set,
   output logic [DEPTH:0]   closed_set
);

   // carry into j = star[j-1] & (seed[j-1] | carry[j-1]):
   // generate = star & seed, propagate = star & ~seed
   logic [DEPTH:0] op_a;
   logic [DEPTH:0] op_b;
   logic [DEPTH:0] sum;
   logic [DEPTH:0] carry;

   assign op_a       = {1'b0, star_mask};
   assign op_b       = {1'b0, star_mask & seed_set[DEPTH-1:0]};
   assign sum        = op_a + op_b;
   assign carry      = sum ^ op_a ^ op_b;
   assign closed_set = seed_set | carry;

endmodule

FILE: hw/rtl/glob_basename_matcher.sv
// Glob basename matcher top level: input stage, bit-parallel active set, result register.
// Depends on gbm_pkg, gbm_star_close and glob_basename_matcher_assert.svh.
`timescale 1ns / 1ps
`include "glob_basename_matcher_assert.svh"

// An end-of-path transfer passes the input stage, then the result register.
// Throughput: one request per cycle unless stalled, any mix of loads, path bytes and
// ends; the whole active-set update is one step plus one carry-chain closure over all
// positions. req_stall rises only when an end request meets a result still held by
// rsp_stall. Reset (synchronous, active high) clears control state and the
// registers; the pattern store is not cleared and holds nothing defined until loaded.
module glob_basename_matcher #(
   parameter int PATTERN_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_position,
   input  logic [7:0] req_char_value,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   // register writes
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   // index into the active set, which has one more entry than the store
   localparam int IDX_W = $clog2(PATTERN_DEPTH + 1);
   // width wide enough for both an 8-bit byte position and any store index
   localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

   // ---------------------------------------------------------------
   // Length clamp and lane mask
   // ---------------------------------------------------------------
   function automatic logic [IDX_W-1:0] clamp_len(input logic [7:0] len);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(len);
      if (ext > CMP_W'(PATTERN_DEPTH)) begin
         return IDX_W'(PATTERN_DEPTH);
      end
      return IDX_W'(ext);
   endfunction

   function automatic logic [PATTERN_DEPTH-1:0] lane_mask(input logic [IDX_W-1:0] n);
      logic [PATTERN_DEPTH-1:0] m;
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         m[i] = (IDX_W'(i) < n);
      end
      return m;
   endfunction

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   logic                     stage_valid_ff, stage_valid_in;
   logic [1:0]               stage_type_ff;
   logic [7:0]               stage_pos_ff;
   logic [7:0]               stage_char_ff;

   logic                     case_insens_ff, case_insens_in;
   logic [7:0]               pattern_len_ff, pattern_len_in;

   logic [7:0]               pattern_ff [PATTERN_DEPTH];
   logic [7:0]               pattern_in [PATTERN_DEPTH];

   logic [PATTERN_DEPTH:0]   active_ff, active_in;
   logic [PATTERN_DEPTH:0]   start_ff, start_in;    // closure of position 0
   logic                     at_start_ff, at_start_in;
   logic [7:0]               name_count_ff, name_count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_matched_ff, rsp_matched_in;

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   logic stage_is_end;
   logic rsp_free;
   logic advance;
   logic accept;

   assign stage_is_end = (stage_type_ff == gbm_pkg::REQ_END);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   // only an end request needs room in the result register
   assign advance      = stage_valid_ff && (!stage_is_end || rsp_free);
   assign req_stall    = stage_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;

   assign stage_valid_in = accept || (stage_valid_ff && !advance);

   // ---------------------------------------------------------------
   // Register writes
   // ---------------------------------------------------------------
   always_comb begin
      case_insens_in = case_insens_ff;
      pattern_len_in = pattern_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            gbm_pkg::REG_CASE_INSENSITIVE: case_insens_in = csr_write_data[0];
            gbm_pkg::REG_PATTERN_LENGTH:   pattern_len_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // One step of the automaton on the current path byte
   // ---------------------------------------------------------------
   logic [IDX_W-1:0]         used_len;
   logic [PATTERN_DEPTH-1:0] mask_now;
   logic [PATTERN_DEPTH-1:0] star_now;
   logic [PATTERN_DEPTH:0]   base_set;
   logic [PATTERN_DEPTH-1:0] lane_stay;
   logic [PATTERN_DEPTH-1:0] lane_adv;
   logic [PATTERN_DEPTH:0]   step_set;
   logic [PATTERN_DEPTH:0]   closed_set;
   logic [7:0]               char_fold;
   logic                     is_sep;

   assign used_len  = clamp_len(pattern_len_ff);
   assign mask_now  = lane_mask(used_len);
   // at name start the active set is the start set, ready in start_ff
   assign base_set  = at_start_ff ? start_ff : active_ff;
   assign char_fold = gbm_pkg::fold_char(case_insens_ff, stage_char_ff);
   assign is_sep    = (stage_char_ff == gbm_pkg::CHAR_SLASH) ||
                      (stage_char_ff == gbm_pkg::CHAR_BSLASH);

   always_comb begin
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         star_now[i]  = mask_now[i] && (pattern_ff[i] == gbm_pkg::CHAR_STAR);
         lane_stay[i] = base_set[i] && star_now[i];
         lane_adv[i]  = base_set[i] && mask_now[i] && !star_now[i] &&
                        ((pattern_ff[i] == gbm_pkg::CHAR_QMARK) ||
                         (gbm_pkg::fold_char(case_insens_ff, pattern_ff[i]) == char_fold));
      end
   end

   assign step_set = {lane_adv, 1'b0} | {1'b0, lane_stay};

   gbm_star_close #(
      .DEPTH(PATTERN_DEPTH)
   ) u_step_close (
      .star_mask  (star_now),
      .seed_set   (step_set),
      .closed_set (closed_set)
   );

   // ---------------------------------------------------------------
   // State update
   // ---------------------------------------------------------------
   always_comb begin
      pattern_in    = pattern_ff;
      active_in     = active_ff;
      at_start_in   = at_start_ff;
      name_count_in = name_count_ff;
      if (advance) begin
         unique case (stage_type_ff)
            gbm_pkg::REQ_LOAD: begin
               // positions past the store match no lane and are dropped
               for (int i = 0; i < PATTERN_DEPTH; i++) begin
                  if (CMP_W'(stage_pos_ff) == CMP_W'(i)) begin
                     pattern_in[i] = stage_char_ff;
                  end
               end
            end
            gbm_pkg::REQ_PATH: begin
               priority if (is_sep) begin
                  at_start_in   = 1'b1;
                  name_count_in = '0;
               end else if (case_insens_ff && (name_count_ff == gbm_pkg::NAME_COUNT_MAX)) begin
                  // folded long name: byte dropped
               end else begin
                  active_in   = closed_set;
                  at_start_in = 1'b0;
                  if (name_count_ff != gbm_pkg::NAME_COUNT_MAX) begin
                     name_count_in = name_count_ff + 8'd1;
                  end
               end
            end
            gbm_pkg::REQ_END: begin
               at_start_in   = 1'b1;
               name_count_in = '0;
            end
            default: ;
         endcase
      end
   end

   // start set tracks the next pattern and length, so it is never stale
   logic [PATTERN_DEPTH-1:0] mask_next;
   logic [PATTERN_DEPTH-1:0] star_next;

   assign mask_next = lane_mask(clamp_len(pattern_len_in));

   always_comb begin
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         star_next[i] = mask_next[i] && (pattern_in[i] == gbm_pkg::CHAR_STAR);
      end
   end

   gbm_star_close #(
      .DEPTH(PATTERN_DEPTH)
   ) u_start_close (
      .star_mask  (star_next),
      .seed_set   ({{PATTERN_DEPTH{1'b0}}, 1'b1}),
      .closed_set (start_in)
   );

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      if (advance && stage_is_end) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = base_set[used_len];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // ---------------------------------------------------------------
   // Flops
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         case_insens_ff <= 1'b0;
         pattern_len_ff <= '0;
         active_ff      <= '0;
         start_ff       <= {{PATTERN_DEPTH{1'b0}}, 1'b1};
         at_start_ff    <= 1'b1;
         name_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         case_insens_ff <= case_insens_in;
         pattern_len_ff <= pattern_len_in;
         active_ff      <= active_in;
         start_ff       <= start_in;
         at_start_ff    <= at_start_in;
         name_count_ff  <= name_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_type_ff <= req_type;
         stage_pos_ff  <= req_position;
         stage_char_ff <= req_char_value;
      end
      pattern_ff     <= pattern_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `GBM_ASSERT_IMP(a_stall_only_on_end, req_stall,
                   stage_is_end && rsp_valid_ff && rsp_stall,
                   "request stalled without a blocked end transfer")
   `GBM_ASSERT_NXT(a_end_gives_result, advance && stage_is_end,
                   rsp_valid_ff && at_start_ff,
                   "end transfer left no result or no name restart")
   `GBM_ASSERT_NXT(a_no_stray_result,
                   !(advance && stage_is_end) && !(rsp_valid_ff && rsp_stall),
                   !rsp_valid_ff, "result appeared without an end transfer")
   `GBM_ASSERT_IMP(a_count_clear_at_start, at_start_ff, name_count_ff == 8'd0,
                   "name count not clear at name start")
   `GBM_ASSERT_IMP(a_start_has_origin, 1'b1, start_ff[0], "start set lost position zero")

endmodule

FILE: test/glob_basename_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for glob_basename_matcher: queued requests, a bit-level
// matcher model and an in-order scoreboard of match results. Depends on gbm_pkg.

module glob_basename_matcher_tb;

   localparam int GLOB_DEPTH  = 256;
   localparam int QUIET_LIMIT = 4000;   // cycles without any transfer
   localparam int ITEM_TARGET = 1850;   // requests over the whole run, roughly
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // literal bytes used for patterns and names: a A b B 0 NUL
   localparam logic [7:0] LITERALS [6] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h30, 8'h00};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] pos;
      logic [7:0] ch;
   } glob_req_type;

   // ---------------------------------------------------------------- DUT side
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_type         = gbm_pkg::REQ_LOAD;
   logic [7:0] req_position     = 8'h00;
   logic [7:0] req_char_value   = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic       rsp_matched;
   logic       csr_write_enable = 1'b0;
   logic       csr_index        = gbm_pkg::REG_CASE_INSENSITIVE;
   logic [7:0] csr_write_data   = 8'h00;

   glob_basename_matcher #(.PATTERN_DEPTH(GLOB_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_position     (req_position),
      .req_char_value   (req_char_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- bench state
   glob_req_type pending_reqs [$];      // filled by the stimulus, drained by the driver
   logic         expected_matches [$];  // match bits still owed by the block
   logic         req_done = 1'b0;       // request transfer at the last rising edge

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int burst_left    = 0;

   int errors         = 0;
   int requests_taken = 0;
   int results_seen   = 0;
   int hits           = 0;
   int reg_writes     = 0;
   int items_queued   = 0;
   int quiet_cycles   = 0;

   // what the stimulus believes sits in the pattern store
   logic [7:0] gen_pat [GLOB_DEPTH];

   // ---------------------------------------------------------------- matcher model
   // Active bit i: the first i pattern bytes match the basename so far.
   logic [7:0]          model_pat [GLOB_DEPTH];
   logic [GLOB_DEPTH:0] model_act   = '0;
   logic                model_fresh = 1'b1;   // next byte opens a new basename
   logic [7:0]          model_count = '0;     // basename bytes taken, saturating
   logic                model_ci    = 1'b0;
   logic [7:0]          model_len   = '0;

   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      if (model_ci && c >= gbm_pkg::CHAR_UPPER_A && c <= gbm_pkg::CHAR_UPPER_Z) begin
         return c + gbm_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   // stars let an active position run on to the next one; ascending order
   // carries the bit through chains of stars
   function automatic void spread_stars();
      for (int i = 0; i < int'(model_len); i++) begin
         if (model_act[i] && model_pat[i] == gbm_pkg::CHAR_STAR) begin
            model_act[i+1] = 1'b1;
         end
      end
   endfunction

   function automatic void open_name();
      model_act    = '0;
      model_act[0] = 1'b1;
      spread_stars();
      model_fresh  = 1'b0;
   endfunction

   function automatic void take_name_byte(input logic [7:0] c);
      logic [GLOB_DEPTH:0] nxt;
      logic [7:0]          fc;
      logic [7:0]          p;
      nxt = '0;
      fc  = fold_byte(c);
      for (int i = 0; i < int'(model_len); i++) begin
         if (model_act[i]) begin
            p = model_pat[i];
            if (p == gbm_pkg::CHAR_STAR) begin
               nxt[i] = 1'b1;
            end else if (p == gbm_pkg::CHAR_QMARK || fold_byte(p) == fc) begin
               nxt[i+1] = 1'b1;
            end
         end
      end
      model_act = nxt;
      spread_stars();
   endfunction

   // advances the model by one request; returns 1 when a match bit is due
   function automatic bit apply_request(input glob_req_type r, output logic hit);
      hit = 1'b0;
      case (r.kind)
         gbm_pkg::REQ_LOAD: begin
            model_pat[r.pos] = r.ch;
            return 1'b0;
         end
         gbm_pkg::REQ_PATH: begin
            if (r.ch == gbm_pkg::CHAR_SLASH || r.ch == gbm_pkg::CHAR_BSLASH) begin
               model_fresh = 1'b1;
               model_count = '0;
            end else if (!(model_ci && model_count == gbm_pkg::NAME_COUNT_MAX)) begin
               // folded names drop bytes past the 255th
               if (model_fresh) begin
                  open_name();
               end
               take_name_byte(r.ch);
               if (model_count != gbm_pkg::NAME_COUNT_MAX) begin
                  model_count++;
               end
            end
            return 1'b0;
         end
         gbm_pkg::REQ_END: begin
            if (model_fresh) begin
               open_name();
            end
            hit         = model_act[model_len];
            model_fresh = 1'b1;
            model_count = '0;
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- monitor
   // Everything is sampled at the rising edge; inputs only move on the falling one.
   always @(posedge clock) begin
      glob_req_type r;
      logic         hit;
      logic         want;
      bit           busy;
      if (!reset) begin
         busy = 1'b0;
         if (csr_write_enable) begin
            if (csr_index == gbm_pkg::REG_CASE_INSENSITIVE) begin
               model_ci = csr_write_data[0];
            end else begin
               model_len = csr_write_data;
            end
            reg_writes++;
         end
         // result first: it always belongs to a request taken at an earlier edge
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            results_seen++;
            if (expected_matches.size() == 0) begin
               $error("matched: expected no transfer, actual %0b", rsp_matched);
               errors++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_matched !== want) begin
                  $error("matched: expected %0b, actual %0b", want, rsp_matched);
                  errors++;
               end
            end
            if (rsp_matched === 1'b1) begin
               hits++;
            end
         end
         if (req_valid && !req_stall) begin
            busy = 1'b1;
            r = {req_type, req_position, req_char_value};
            if (apply_request(r, hit)) begin
               expected_matches.push_back(hit);
            end
            requests_taken++;
            req_done <= 1'b1;
         end else begin
            req_done <= 1'b0;
         end
         if (busy) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- driver
   // A payload is held until its transfer; a fresh one is only presented once the
   // previous one has gone, so valid never waits on stall. Short bursts with no
   // idling on either side are mixed into every phase.
   always @(negedge clock) begin
      glob_req_type r;
      if (!reset) begin
         if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(99) < 2) begin
            burst_left = 24;
         end
         if (!req_valid || req_done) begin
            if (pending_reqs.size() > 0 &&
                (burst_left > 0 || $urandom_range(99) >= send_idle_pct)) begin
               r = pending_reqs.pop_front();
               req_valid      <= 1'b1;
               req_type       <= r.kind;
               req_position   <= r.pos;
               req_char_value <= r.ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (burst_left == 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   task automatic push_req(input logic [1:0] kind, input logic [7:0] pos,
                           input logic [7:0] ch);
      pending_reqs.push_back({kind, pos, ch});
      if (kind != REQ_UNUSED) begin
         items_queued++;
      end
      if (kind == gbm_pkg::REQ_LOAD) begin
         gen_pat[pos] = ch;
      end
   endtask

   // block idle: nothing queued or on the wire, nothing owed, plus a latency margin
   task automatic settle();
      do begin
         @(posedge clock);
      end while (pending_reqs.size() != 0 || req_valid || expected_matches.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input gbm_pkg::csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] pick_glob_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) begin
         return gbm_pkg::CHAR_STAR;
      end
      if (roll < 35) begin
         return gbm_pkg::CHAR_QMARK;
      end
      if (roll < 45) begin
         return 8'($urandom_range(255));
      end
      return LITERALS[3'($urandom_range(5))];
   endfunction

   // any byte but a separator
   function automatic logic [7:0] pick_name_byte();
      logic [7:0] c;
      if ($urandom_range(3) == 0) begin
         c = 8'($urandom_range(255));
      end else begin
         c = LITERALS[3'($urandom_range(5))];
      end
      if (c == gbm_pkg::CHAR_SLASH || c == gbm_pkg::CHAR_BSLASH) begin
         c = 8'h71;
      end
      return c;
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      if (c >= gbm_pkg::CHAR_UPPER_A && c <= gbm_pkg::CHAR_UPPER_Z) begin
         return c + gbm_pkg::CASE_OFFSET;
      end
      if (c >= gbm_pkg::CHAR_UPPER_A + gbm_pkg::CASE_OFFSET &&
          c <= gbm_pkg::CHAR_UPPER_Z + gbm_pkg::CASE_OFFSET) begin
         return c - gbm_pkg::CASE_OFFSET;
      end
      return c;
   endfunction

   // A name built to match the first plen pattern bytes, sometimes spoilt, sometimes
   // behind a directory part; stray loads and unknown requests land mid-name.
   task automatic push_name(input int plen, input bit fold_on);
      logic [7:0] body [$];
      logic [7:0] c;
      int         n;
      int         k;
      if ($urandom_range(99) < 30) begin
         n = $urandom_range(1, 4);
         repeat (n) push_req(gbm_pkg::REQ_PATH, 8'($urandom), pick_name_byte());
         push_req(gbm_pkg::REQ_PATH, 8'($urandom),
                  $urandom_range(1) ? gbm_pkg::CHAR_SLASH : gbm_pkg::CHAR_BSLASH);
      end
      for (int i = 0; i < plen; i++) begin
         c = gen_pat[i];
         if (c == gbm_pkg::CHAR_STAR) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            repeat (n) body.push_back(pick_name_byte());
         end else if (c == gbm_pkg::CHAR_QMARK || c == gbm_pkg::CHAR_SLASH ||
                      c == gbm_pkg::CHAR_BSLASH) begin
            body.push_back(pick_name_byte());
         end else begin
            body.push_back((fold_on && $urandom_range(1)) ? flip_case(c) : c);
         end
      end
      if ($urandom_range(3) == 0) begin
         k = (body.size() > 0) ? $urandom_range(body.size() - 1) : 0;
         case ($urandom_range(2))
            0: begin
               body.push_back(pick_name_byte());
            end
            1: begin
               if (body.size() > 0) body.delete(k);
            end
            default: begin
               if (body.size() > 0) body[k] = pick_name_byte();
            end
         endcase
      end
      foreach (body[i]) begin
         if ($urandom_range(49) == 0) begin
            push_req(gbm_pkg::REQ_LOAD, 8'($urandom_range(plen)), pick_glob_byte());
         end
         if ($urandom_range(49) == 0) begin
            push_req(REQ_UNUSED, 8'($urandom), 8'($urandom));
         end
         push_req(gbm_pkg::REQ_PATH, 8'($urandom), body[i]);
      end
      push_req(gbm_pkg::REQ_END, 8'($urandom), 8'($urandom));
   endtask

   // basename past the 255-byte mark, optionally followed by a fresh component
   task automatic push_long_name();
      int n;
      n = $urandom_range(256, 300);
      repeat (n) push_req(gbm_pkg::REQ_PATH, 8'($urandom), LITERALS[3'($urandom_range(3))]);
      if ($urandom_range(1)) begin
         push_req(gbm_pkg::REQ_PATH, 8'($urandom), gbm_pkg::CHAR_SLASH);
         push_req(gbm_pkg::REQ_PATH, 8'($urandom), LITERALS[3'($urandom_range(3))]);
      end
      push_req(gbm_pkg::REQ_END, 8'($urandom), 8'($urandom));
   endtask

   // ---------------------------------------------------------------- test sequence
   initial begin
      int directed_items;
      int rounds;
      int plen;
      int names;
      bit fold_on;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // whole store written first, so no entry is ever read unwritten
      for (int i = 0; i < GLOB_DEPTH; i++) begin
         push_req(gbm_pkg::REQ_LOAD, 8'(i), pick_glob_byte());
      end

      // ---- directed: empty pattern
      settle();
      write_reg(gbm_pkg::REG_CASE_INSENSITIVE, 8'h00);
      write_reg(gbm_pkg::REG_PATTERN_LENGTH, 8'h00);
      push_req(gbm_pkg::REQ_END, 8'hFF, 8'hFF);              // empty name
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h61);
      push_req(gbm_pkg::REQ_END, 8'h00, 8'h00);              // one byte, nothing to match
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h61);
      push_req(gbm_pkg::REQ_PATH, 8'h00, gbm_pkg::CHAR_SLASH);
      push_req(gbm_pkg::REQ_END, 8'h00, 8'h00);              // empty basename after a slash
      // pattern "A?*", plus the top store entry
      push_req(gbm_pkg::REQ_LOAD, 8'd0, gbm_pkg::CHAR_UPPER_A);
      push_req(gbm_pkg::REQ_LOAD, 8'd1, gbm_pkg::CHAR_QMARK);
      push_req(gbm_pkg::REQ_LOAD, 8'd2, gbm_pkg::CHAR_STAR);
      push_req(gbm_pkg::REQ_LOAD, 8'hFF, 8'hFF);
      settle();
      write_reg(gbm_pkg::REG_PATTERN_LENGTH, 8'd3);
      push_req(gbm_pkg::REQ_PATH, 8'h00, gbm_pkg::CHAR_UPPER_A);
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h62);
      push_req(gbm_pkg::REQ_END, 8'h00, 8'h00);              // hit, trailing star empty
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h61);
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h62);
      push_req(gbm_pkg::REQ_END, 8'h00, 8'h00);              // case differs, no fold
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h78);
      push_req(gbm_pkg::REQ_PATH, 8'h00, gbm_pkg::CHAR_BSLASH);
      push_req(gbm_pkg::REQ_PATH, 8'h00, gbm_pkg::CHAR_UPPER_A);
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h62);
      push_req(gbm_pkg::REQ_END, 8'h00, 8'h00);              // backslash restarts matching
      // folding on: case ignored; a load mid-name puts a NUL literal in the pattern
      settle();
      write_reg(gbm_pkg::REG_CASE_INSENSITIVE, 8'h01);
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h61);
      push_req(gbm_pkg::REQ_LOAD, 8'd1, 8'h00);
      push_req(gbm_pkg::REQ_PATH, 8'h00, 8'h00);
      push_req(REQ_UNUSED, 8'hFF, 8'hFF);                    // ignored outright
      push_req(gbm_pkg::REQ_END, 8'h00, 8'h00);
      directed_items = items_queued;

      // ---- random: one idle mix per phase, new register values every round
      rounds = 0;
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         while (items_queued <
                directed_items + (ITEM_TARGET - directed_items) * (mode + 1) / 4) begin
            settle();
            rounds++;
            fold_on = $urandom_range(1);
            if (rounds % 25 == 12) begin
               plen = 255;
            end else if ($urandom_range(9) < 7) begin
               plen = $urandom_range(0, 8);
            end else begin
               plen = $urandom_range(9, 40);
            end
            // a name left open by the last round carries across these writes
            write_reg(gbm_pkg::REG_CASE_INSENSITIVE, 8'(fold_on));
            write_reg(gbm_pkg::REG_PATTERN_LENGTH, 8'(plen));
            if (plen <= 40 && $urandom_range(1)) begin
               for (int i = 0; i < plen; i++) begin
                  push_req(gbm_pkg::REQ_LOAD, 8'(i), pick_glob_byte());
               end
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  push_req(gbm_pkg::REQ_LOAD, 8'($urandom_range(plen)), pick_glob_byte());
               end
            end
            names = (plen > 40) ? 1 : $urandom_range(2, 6);
            repeat (names) push_name(plen, fold_on);
            if (rounds % 15 == 7) begin
               push_long_name();
            end
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  push_req(gbm_pkg::REQ_PATH, 8'($urandom), pick_name_byte());
               end
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("Run: %0d requests taken, %0d match results checked (%0d hits), %0d reg writes",
               requests_taken, results_seen, hits, reg_writes);
      $display("Both case modes, pattern lengths 0 to 255, separators, long names, four idle mixes");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
